[rtl/core/spiral_kth_element_lookup_core_macros.svh]
// assertion macros for the spiral k-th element lookup core
// no dependencies; taken in by the rtl files that carry assertions
`ifndef SPIRAL_KTH_ELEMENT_LOOKUP_CORE_MACROS_SVH
`define SPIRAL_KTH_ELEMENT_LOOKUP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SKL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in spiral lookup core");
`define SKL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in spiral lookup core");
`else
`define SKL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SKL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/core/skl_pkg.sv]
// shared types and constants of the spiral k-th element lookup core
// no dependencies; used by the ring walk unit and the top level
`default_nettype none

package skl_pkg;

   localparam int COUNT_W    = 6;   // row and column count registers
   localparam int ROWCOL_W   = 5;   // row and column fields of a request
   localparam int ELEM_W     = 32;  // element value field
   localparam int POS_W      = 11;  // spiral position field
   localparam int WALK_W     = 14;  // signed working width of the ring walk
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_BIT = 2;

   localparam int REQ_TDATA_W = 56;
   localparam int REQ_ROW_LSB = 0;
   localparam int REQ_COL_LSB = 5;
   localparam int REQ_VAL_LSB = 10;
   localparam int REQ_POS_LSB = 42;

   localparam int RSP_TDATA_W = 48;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic REG_ROW_COUNT    = 1'b0;
   localparam logic REG_COLUMN_COUNT = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_READ,
      ST_PUSH
   } ctrl_state_type;

   typedef struct packed {
      logic               done;
      logic               error;
      logic [COUNT_W-1:0] row;
      logic [COUNT_W-1:0] col;
   } walk_result_type;

endpackage

`default_nettype wire

[rtl/core/skl_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module skl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/skl_ring_walk.sv]
// ring walk unit: finds the row and column of a spiral position, one ring a cycle
// depends on skl_pkg
`default_nettype none

module skl_ring_walk #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [skl_pkg::POS_W-1:0]     position,
   input  wire logic [skl_pkg::COUNT_W-1:0]   rows,
   input  wire logic [skl_pkg::COUNT_W-1:0]   cols,
   output skl_pkg::walk_result_type           result
);

   localparam int W       = skl_pkg::WALK_W;
   localparam int CW      = skl_pkg::COUNT_W;
   localparam int LVL_MAX = MAX_ROWS + MAX_COLS;
   localparam int LVL_W   = $clog2(LVL_MAX + 1);
   localparam logic signed [W-1:0] ONE = W'(1);
   localparam logic signed [W-1:0] TWO = W'(2);

   logic                      busy_ff, busy_in;
   logic signed [W-1:0]       k_ff, k_in;
   logic [LVL_W-1:0]          lvl_ff, lvl_in;
   skl_pkg::walk_result_type  result_ff, result_in;

   logic [2*CW-1:0]     area;
   logic                bad_start;
   logic signed [W-1:0] lvl_s, lvl2, rows_s, cols_s;
   logic signed [W-1:0] len0, len1, len2, len3;
   logic signed [W-1:0] k1, k2, k3, k4;
   logic                hit0, hit1, hit2, hit3;
   logic signed [W-1:0] fr, fc;
   logic                out_of_matrix;

   always_comb begin
      area      = (2*CW)'(rows) * (2*CW)'(cols);
      bad_start = (position == '0) || ((2*CW)'(position) > area);

      lvl_s  = $signed(W'(lvl_ff));
      lvl2   = lvl_s + lvl_s;
      rows_s = $signed(W'(rows));
      cols_s = $signed(W'(cols));

      // top, right, bottom and left runs of the current ring
      len0 = cols_s - lvl2;
      hit0 = len0 >= k_ff;
      k1   = k_ff - len0;
      len1 = rows_s - ONE - lvl2;
      hit1 = len1 >= k1;
      k2   = k1 - len1;
      len2 = cols_s - ONE - lvl2;
      hit2 = len2 >= k2;
      k3   = k2 - len2;
      len3 = rows_s - TWO - lvl2;
      hit3 = len3 >= k3;
      k4   = k3 - len3;

      priority if (hit0) begin
         fr = lvl_s;
         fc = k_ff - ONE + lvl_s;
      end else if (hit1) begin
         fr = k1 + lvl_s;
         fc = cols_s - ONE - lvl_s;
      end else if (hit2) begin
         fr = rows_s - ONE - lvl_s;
         fc = cols_s - ONE - k2 - lvl_s;
      end else begin
         fr = rows_s - ONE - lvl_s - k3;
         fc = lvl_s;
      end
      out_of_matrix = (fr < 0) || (fc < 0) || (fr >= rows_s) || (fc >= cols_s);

      busy_in   = busy_ff;
      k_in      = k_ff;
      lvl_in    = lvl_ff;
      result_in = '0;

      if (start) begin
         if (bad_start) begin
            result_in.done  = 1'b1;
            result_in.error = 1'b1;
            busy_in         = 1'b0;
         end else begin
            busy_in = 1'b1;
            k_in    = $signed(W'(position));
            lvl_in  = '0;
         end
      end else if (busy_ff) begin
         if (hit0 || hit1 || hit2 || hit3) begin
            busy_in         = 1'b0;
            result_in.done  = 1'b1;
            result_in.error = out_of_matrix;
            result_in.row   = out_of_matrix ? '0 : fr[CW-1:0];
            result_in.col   = out_of_matrix ? '0 : fc[CW-1:0];
         end else if (lvl_ff == LVL_W'(LVL_MAX)) begin
            busy_in         = 1'b0;
            result_in.done  = 1'b1;
            result_in.error = 1'b1;
         end else begin
            k_in   = k4;
            lvl_in = lvl_ff + LVL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         result_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         result_ff <= result_in;
      end
      k_ff   <= k_in;
      lvl_ff <= lvl_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

[rtl/core/spiral_kth_element_lookup_core.sv]
// top level of the spiral k-th element lookup core
// depends on skl_pkg, skl_ram, skl_ring_walk and the assertion macro header
//
// usage
//   request channel (req_*): one request per handshake, tuser carries the
//   command (store or query), tdata the row, column, value and spiral position
//   response channel (rsp_*): exactly one response per request, in order
//   csr port: row count at byte 0, column count at byte 4, written values are
//   clamped to 1..MAX_ROWS / 1..MAX_COLS, read back as held
// request flow
//   a store writes the matrix ram when it is taken, then goes through the push
//   state into the output register; a query goes through the ring walk unit
//   (one ring per cycle) until the position is hit, one registered read of the
//   matrix ram and the push state; the next request is taken only once the core
//   is back in idle
//   a position out of range is answered with range_error set and no ram read
// reset and stalls
//   reset returns the counts to 4 by 4 and drops any request in flight;
//   the matrix ram is not cleared, an entry read before it is written is
//   undefined
//   a finished response waits in the output register; one more request is
//   taken and worked while it waits, and the core then holds until it drains
`default_nettype none
`include "spiral_kth_element_lookup_core_macros.svh"

module spiral_kth_element_lookup_core #(
   parameter int MAX_ROWS   = 32,
   parameter int MAX_COLS   = 32,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: write_row[4:0], write_col[9:5], write_value[41:10],
   //        spiral_position[52:42], zero fill up to 56 bits
   input  wire logic [skl_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // tuser: cmd (0 store, 1 query)
   input  wire logic                                req_tuser,
   // response channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata: element_value[31:0], found_row[36:32], found_col[41:37],
   //        zero fill up to 48 bits
   output logic      [skl_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // tuser: range_error
   output logic                                     rsp_tuser,
   // csr port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [skl_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [skl_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [skl_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                     csr_pready
);

   localparam int CW     = skl_pkg::COUNT_W;
   localparam int RCW    = skl_pkg::ROWCOL_W;
   localparam int EW     = skl_pkg::ELEM_W;
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W = CW + $clog2(MAX_COLS + 1) + 1;

   // request fields
   logic                              req_cmd;
   logic [RCW-1:0]                    req_row, req_col;
   logic [EW-1:0]                     req_value;
   logic [skl_pkg::POS_W-1:0]         req_pos;
   logic                              req_accept;

   assign req_cmd    = req_tuser;
   assign req_row    = req_tdata[skl_pkg::REQ_ROW_LSB +: RCW];
   assign req_col    = req_tdata[skl_pkg::REQ_COL_LSB +: RCW];
   assign req_value  = req_tdata[skl_pkg::REQ_VAL_LSB +: EW];
   assign req_pos    = req_tdata[skl_pkg::REQ_POS_LSB +: skl_pkg::POS_W];
   assign req_accept = req_tvalid && req_tready;

   // configuration registers
   logic [CW-1:0] row_count_ff, row_count_in;
   logic [CW-1:0] column_count_ff, column_count_in;
   logic [CW-1:0] wr_count, row_clamp, col_clamp;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      wr_count  = csr_pwdata[CW-1:0];
      // a zero count reads as one, a count above the array saturates
      row_clamp = (wr_count == '0) ? CW'(1) : wr_count;
      if (int'(row_clamp) > MAX_ROWS) begin
         row_clamp = CW'(MAX_ROWS);
      end
      col_clamp = (wr_count == '0) ? CW'(1) : wr_count;
      if (int'(col_clamp) > MAX_COLS) begin
         col_clamp = CW'(MAX_COLS);
      end
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_wr) begin
         unique case (csr_paddr[skl_pkg::CSR_INDEX_BIT])
            skl_pkg::REG_ROW_COUNT:    row_count_in    = row_clamp;
            skl_pkg::REG_COLUMN_COUNT: column_count_in = col_clamp;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[skl_pkg::CSR_INDEX_BIT])
         skl_pkg::REG_ROW_COUNT:    csr_prdata = skl_pkg::CSR_DATA_W'(row_count_ff);
         skl_pkg::REG_COLUMN_COUNT: csr_prdata = skl_pkg::CSR_DATA_W'(column_count_ff);
      endcase
   end

   // ring walk unit
   logic                      walk_start;
   skl_pkg::walk_result_type  walk_res;

   skl_ring_walk #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .start    (walk_start),
      .position (req_pos),
      .rows     (row_count_ff),
      .cols     (column_count_ff),
      .result   (walk_res)
   );

   // matrix ram, entry (r,c) at r*MAX_COLS+c
   logic                  ram_wr_en, ram_rd_en;
   logic [PROD_W-1:0]     store_addr_wide, query_addr_wide;
   logic [ADDR_W-1:0]     store_addr, query_addr;
   logic [DATA_WIDTH-1:0] ram_wr_data, ram_rd_data;
   logic [EW-1:0]         rd_value;
   logic                  store_in_array;

   assign store_addr_wide = PROD_W'(req_row) * PROD_W'(MAX_COLS) + PROD_W'(req_col);
   assign store_addr      = ADDR_W'(store_addr_wide);
   assign query_addr_wide = PROD_W'(walk_res.row) * PROD_W'(MAX_COLS)
                          + PROD_W'(walk_res.col);
   assign query_addr      = ADDR_W'(query_addr_wide);
   // stores outside the array are dropped, those outside the counts are kept
   assign store_in_array  = (int'(req_row) < MAX_ROWS) && (int'(req_col) < MAX_COLS);

   generate
      if (DATA_WIDTH <= EW) begin : g_narrow_store
         assign ram_wr_data = req_value[DATA_WIDTH-1:0];
      end else begin : g_wide_store
         assign ram_wr_data = {{(DATA_WIDTH-EW){1'b0}}, req_value};
      end
      if (DATA_WIDTH >= EW) begin : g_wide_read
         assign rd_value = ram_rd_data[EW-1:0];
      end else begin : g_narrow_read
         // sign extend from the stored width
         assign rd_value = {{(EW-DATA_WIDTH){ram_rd_data[DATA_WIDTH-1]}}, ram_rd_data};
      end
   endgenerate

   skl_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (store_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (query_addr),
      .rd_data (ram_rd_data)
   );

   // control: writes only happen on an accepted store in idle and reads only
   // at the end of a walk, so the two ports never touch the ram together
   skl_pkg::ctrl_state_type state_ff, state_in;

   logic [EW-1:0]  pend_value_ff, pend_value_in;
   logic [RCW-1:0] pend_row_ff, pend_row_in;
   logic [RCW-1:0] pend_col_ff, pend_col_in;
   logic           pend_err_ff, pend_err_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0]  rsp_value_ff, rsp_value_in;
   logic [RCW-1:0] rsp_row_ff, rsp_row_in;
   logic [RCW-1:0] rsp_col_ff, rsp_col_in;
   logic           rsp_err_ff, rsp_err_in;

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      walk_start    = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      pend_value_in = pend_value_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      pend_err_in   = pend_err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_err_in    = rsp_err_ff;

      unique case (state_ff)
         skl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_cmd == skl_pkg::CMD_STORE) begin
                  ram_wr_en     = store_in_array;
                  pend_value_in = '0;
                  pend_row_in   = '0;
                  pend_col_in   = '0;
                  pend_err_in   = 1'b0;
                  state_in      = skl_pkg::ST_PUSH;
               end else begin
                  walk_start = 1'b1;
                  state_in   = skl_pkg::ST_WALK;
               end
            end
         end
         skl_pkg::ST_WALK: begin
            if (walk_res.done) begin
               if (walk_res.error) begin
                  pend_value_in = '0;
                  pend_row_in   = '0;
                  pend_col_in   = '0;
                  pend_err_in   = 1'b1;
                  state_in      = skl_pkg::ST_PUSH;
               end else begin
                  ram_rd_en   = 1'b1;
                  pend_row_in = walk_res.row[RCW-1:0];
                  pend_col_in = walk_res.col[RCW-1:0];
                  pend_err_in = 1'b0;
                  state_in    = skl_pkg::ST_READ;
               end
            end
         end
         skl_pkg::ST_READ: begin
            // registered ram data is valid in this cycle
            pend_value_in = rd_value;
            state_in      = skl_pkg::ST_PUSH;
         end
         skl_pkg::ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = pend_value_ff;
               rsp_row_in   = pend_row_ff;
               rsp_col_in   = pend_col_ff;
               rsp_err_in   = pend_err_ff;
               state_in     = skl_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= skl_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         row_count_ff    <= skl_pkg::COUNT_RESET;
         column_count_ff <= skl_pkg::COUNT_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
      end
      pend_value_ff <= pend_value_in;
      pend_row_ff   <= pend_row_in;
      pend_col_ff   <= pend_col_in;
      pend_err_ff   <= pend_err_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tdata  = {{(skl_pkg::RSP_TDATA_W-EW-2*RCW){1'b0}},
                        rsp_col_ff, rsp_row_ff, rsp_value_ff};

   // checks
   `SKL_ASSERT_IMP(a_walk_hit_in_matrix, clock, reset, walk_res.done && !walk_res.error, (walk_res.row < row_count_ff) && (walk_res.col < column_count_ff))
   `SKL_ASSERT_IMP(a_walk_done_while_waiting, clock, reset, walk_res.done, state_ff == skl_pkg::ST_WALK)
   `SKL_ASSERT_IMP(a_no_ram_port_clash, clock, reset, ram_rd_en, !ram_wr_en)
   `SKL_ASSERT_IMP(a_error_payload_clear, clock, reset, rsp_valid_ff && rsp_err_ff, rsp_tdata == '0)
   `SKL_ASSERT_NEXT(a_query_enters_walk, clock, reset, req_accept && (req_cmd == skl_pkg::CMD_QUERY), state_ff == skl_pkg::ST_WALK)

endmodule

`default_nettype wire

[tb/sv/spiral_lookup_checker.sv]
// response checker for the spiral k-th element lookup core testbench
// depends on skl_pkg; watches the request, response and csr channels,
// keeps its own copy of the matrix and the counts and compares every response
module spiral_lookup_checker
   import skl_pkg::*;
#(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                   rsp_tuser,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  wire logic                   csr_pready,
   output int                          error_count,
   output int                          outstanding
);

   typedef struct packed {
      logic signed [ELEM_W-1:0] value;
      logic [ROWCOL_W-1:0]      row;
      logic [ROWCOL_W-1:0]      col;
      logic                     range_error;
   } lookup_answer_t;

   logic signed [ELEM_W-1:0] element_shadow [MAX_ROWS*MAX_COLS];
   logic [COUNT_W-1:0]       rows_in_use;
   logic [COUNT_W-1:0]       cols_in_use;
   lookup_answer_t           expected_answers [$];

   initial begin
      foreach (element_shadow[i]) element_shadow[i] = '0;
   end

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [CSR_DATA_W-1:0] raw,
                                                     input int limit);
      logic [COUNT_W-1:0] cnt;
      cnt = raw[COUNT_W-1:0];
      if (cnt == 0) cnt = COUNT_W'(1);
      if (int'(cnt) > limit) cnt = COUNT_W'(limit);
      return cnt;
   endfunction

   // store updates the shadow matrix; query peels rings off until k lands in a run
   function automatic lookup_answer_t answer_request(input logic cmd,
                                                     input logic [REQ_TDATA_W-1:0] data);
      lookup_answer_t      ans;
      logic [ROWCOL_W-1:0] wr_row;
      logic [ROWCOL_W-1:0] wr_col;
      int                  rows, cols, remaining, ring, hit_r, hit_c;
      ans    = '0;
      wr_row = data[REQ_ROW_LSB +: ROWCOL_W];
      wr_col = data[REQ_COL_LSB +: ROWCOL_W];
      if (cmd == CMD_STORE) begin
         if (int'(wr_row) < MAX_ROWS && int'(wr_col) < MAX_COLS)
            element_shadow[int'(wr_row) * MAX_COLS + int'(wr_col)] =
               data[REQ_VAL_LSB +: ELEM_W];
         return ans;
      end
      rows      = int'(rows_in_use);
      cols      = int'(cols_in_use);
      remaining = int'(data[REQ_POS_LSB +: POS_W]);
      hit_r     = -1;
      hit_c     = -1;
      if (remaining == 0 || remaining > rows * cols) begin
         ans.range_error = 1'b1;
         return ans;
      end
      for (ring = 0; ring <= MAX_ROWS + MAX_COLS; ring++) begin
         // top run, left to right
         if (remaining <= cols - 2*ring) begin
            hit_r = ring;
            hit_c = ring + remaining - 1;
            break;
         end
         remaining -= cols - 2*ring;
         // right run, downwards
         if (remaining <= rows - 1 - 2*ring) begin
            hit_r = ring + remaining;
            hit_c = cols - 1 - ring;
            break;
         end
         remaining -= rows - 1 - 2*ring;
         // bottom run, right to left
         if (remaining <= cols - 1 - 2*ring) begin
            hit_r = rows - 1 - ring;
            hit_c = cols - 1 - ring - remaining;
            break;
         end
         remaining -= cols - 1 - 2*ring;
         // left run, upwards
         if (remaining <= rows - 2 - 2*ring) begin
            hit_r = rows - 1 - ring - remaining;
            hit_c = ring;
            break;
         end
         remaining -= rows - 2 - 2*ring;
      end
      if (hit_r < 0 || hit_c < 0 || hit_r >= rows || hit_c >= cols) begin
         ans.range_error = 1'b1;
         return ans;
      end
      ans.value = element_shadow[hit_r * MAX_COLS + hit_c];
      ans.row   = ROWCOL_W'(hit_r);
      ans.col   = ROWCOL_W'(hit_c);
      return ans;
   endfunction

   always @(posedge clock) begin : monitor
      lookup_answer_t got;
      lookup_answer_t want;
      if (reset) begin
         rows_in_use = COUNT_RESET;
         cols_in_use = COUNT_RESET;
         expected_answers.delete();
         outstanding <= 0;
         error_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[CSR_INDEX_BIT] == REG_ROW_COUNT)
               rows_in_use = clamp_count(csr_pwdata, MAX_ROWS);
            else
               cols_in_use = clamp_count(csr_pwdata, MAX_COLS);
         end
         // responses first: one landing with a request cannot belong to it
         if (rsp_tvalid && rsp_tready) begin
            got.value       = rsp_tdata[ELEM_W-1:0];
            got.row         = rsp_tdata[ELEM_W +: ROWCOL_W];
            got.col         = rsp_tdata[ELEM_W+ROWCOL_W +: ROWCOL_W];
            got.range_error = rsp_tuser;
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected response, expected none, got value %h row %0d col %0d err %b",
                        $time, got.value, got.row, got.col, got.range_error);
               error_count <= error_count + 1;
            end else begin
               want = expected_answers.pop_front();
               if (got !== want) begin
                  $display("%0t: response mismatch, expected value %h row %0d col %0d err %b, got value %h row %0d col %0d err %b",
                           $time, want.value, want.row, want.col, want.range_error,
                           got.value, got.row, got.col, got.range_error);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_answers.push_back(answer_request(req_tuser, req_tdata));
         outstanding <= expected_answers.size();
      end
   end

endmodule

[tb/sv/spiral_kth_element_lookup_core_tb.sv]
// top of the spiral k-th element lookup core testbench: clock, reset, stimulus
// depends on skl_pkg, the core and spiral_lookup_checker, which does all checking
module spiral_kth_element_lookup_core_tb;
   import skl_pkg::*;

   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 32;
   localparam int PHASES   = 9;
   localparam int PHASE_ITEMS = 103;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = CMD_STORE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int fail_count;
   int outstanding;

   // idling knobs, percent of cycles
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;

   // counts as the core holds them, and the cells in spiral order for them;
   // the spiral order is only used to keep queries off cells that were never written
   int unsigned rows_used = 4;
   int unsigned cols_used = 4;
   int unsigned spiral_cell [MAX_ROWS*MAX_COLS];
   bit          cell_written [MAX_ROWS*MAX_COLS];

   // per phase: raw count values (some out of range on purpose)
   int unsigned phase_rows [PHASES] = '{0, 32, 5, 63, 1, 6, 32, 17, 2};
   int unsigned phase_cols [PHASES] = '{32, 1, 7, 32, 0, 3, 33, 2, 9};

   spiral_kth_element_lookup_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   spiral_lookup_checker #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .error_count (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver side: ready drops at random according to the phase's stall rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // request tdata: row, column, value, position from the low bits up, zero fill on top
   function automatic logic [REQ_TDATA_W-1:0] pack_request(input logic [ROWCOL_W-1:0] row,
                                                         input logic [ROWCOL_W-1:0] col,
                                                         input logic [ELEM_W-1:0]   value,
                                                         input logic [POS_W-1:0]    pos);
      return {{(REQ_TDATA_W - POS_W - ELEM_W - 2*ROWCOL_W){1'b0}}, pos, value, col, row};
   endfunction

   function automatic int unsigned count_in_use(input int unsigned raw, input int unsigned limit);
      int unsigned cnt;
      cnt = raw % 64;
      if (cnt == 0) cnt = 1;
      if (cnt > limit) cnt = limit;
      return cnt;
   endfunction

   // list the cells by walking the boundary inwards, turning at each edge
   task automatic build_spiral_order();
      int top_r, bot_r, left_c, right_c, n;
      top_r   = 0;
      bot_r   = rows_used - 1;
      left_c  = 0;
      right_c = cols_used - 1;
      n       = 0;
      while (top_r <= bot_r && left_c <= right_c) begin
         for (int c = left_c; c <= right_c; c++) begin
            spiral_cell[n] = top_r * MAX_COLS + c;
            n++;
         end
         for (int r = top_r + 1; r <= bot_r; r++) begin
            spiral_cell[n] = r * MAX_COLS + right_c;
            n++;
         end
         if (top_r < bot_r) begin
            for (int c = right_c - 1; c >= left_c; c--) begin
               spiral_cell[n] = bot_r * MAX_COLS + c;
               n++;
            end
         end
         if (left_c < right_c) begin
            for (int r = bot_r - 1; r > top_r; r--) begin
               spiral_cell[n] = r * MAX_COLS + left_c;
               n++;
            end
         end
         top_r++;
         bot_r--;
         left_c++;
         right_c--;
      end
   endtask

   // one request: random idle gap, then hold valid until the core takes it
   task automatic push_request(input logic cmd, input logic [REQ_TDATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop sending and wait until every request has been answered
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic issue_store(input int unsigned row, input int unsigned col,
                              input logic [ELEM_W-1:0] value);
      cell_written[row * MAX_COLS + col] = 1'b1;
      push_request(CMD_STORE, pack_request(ROWCOL_W'(row), ROWCOL_W'(col), value,
                                           POS_W'($urandom)));
   endtask

   // a query whose cell was never written turns into a store of that cell instead
   task automatic issue_query(input int unsigned pos);
      int unsigned cell_idx;
      cell_idx = 0;
      if (pos >= 1 && pos <= rows_used * cols_used) cell_idx = spiral_cell[pos - 1];
      if (pos >= 1 && pos <= rows_used * cols_used && !cell_written[cell_idx])
         issue_store(cell_idx / MAX_COLS, cell_idx % MAX_COLS, $urandom);
      else
         push_request(CMD_QUERY, pack_request(ROWCOL_W'($urandom), ROWCOL_W'($urandom),
                                              $urandom, POS_W'(pos)));
   endtask

   // apb write: setup cycle, then access cycle held until pready
   task automatic csr_write(input logic reg_idx, input int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(reg_idx) << CSR_INDEX_BIT;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_idx == REG_ROW_COUNT) rows_used = count_in_use(value, MAX_ROWS);
      else cols_used = count_in_use(value, MAX_COLS);
   endtask

   function automatic logic [ELEM_W-1:0] pick_value();
      case ($urandom_range(19))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      int unsigned pos, area;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      build_spiral_order();
      @(posedge clock);

      // directed part under the reset counts (4 by 4): corners, extreme values,
      // a store outside the configured counts, both range limits and an overwrite
      issue_store(0, 0, 32'h7fff_ffff);
      issue_store(0, 3, 32'h8000_0000);
      issue_store(3, 3, 32'hffff_ffff);
      issue_store(3, 0, 32'h0000_0000);
      issue_store(1, 1, 32'h5a5a_5a5a);
      issue_store(2, 1, 32'ha5a5_a5a5);
      issue_store(0, 1, 32'h1234_5678);
      push_request(CMD_STORE, pack_request('1, '1, '1, '1));
      cell_written[MAX_ROWS*MAX_COLS - 1] = 1'b1;
      issue_query(0);
      issue_query(1);
      issue_query(2);
      issue_query(4);
      issue_query(7);
      issue_query(10);
      issue_query(13);
      issue_query(16);
      issue_query(17);
      push_request(CMD_QUERY, pack_request('1, '1, '1, '1));
      issue_store(1, 1, 32'h0000_0001);
      issue_query(13);
      drain();

      // random part: one count setting per phase, idling mix rotating through
      // none, sender idle, receiver stall and both
      for (int ph = 0; ph < PHASES; ph++) begin
         repeat (4) @(posedge clock);
         csr_write(REG_ROW_COUNT, phase_rows[ph]);
         csr_write(REG_COLUMN_COUNT, phase_cols[ph]);
         build_spiral_order();
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 87; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 87; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
         endcase
         area = rows_used * cols_used;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // halfway through, hold off until the core has answered everything
            if (n == PHASE_ITEMS / 2) drain();
            if ($urandom_range(99) < 35) begin
               // stores mostly inside the counts in use, now and then anywhere
               if ($urandom_range(3) != 0)
                  issue_store($urandom_range(rows_used - 1), $urandom_range(cols_used - 1),
                              pick_value());
               else
                  issue_store($urandom_range(MAX_ROWS - 1), $urandom_range(MAX_COLS - 1),
                              pick_value());
            end else begin
               case ($urandom_range(19))
                  0:       pos = 0;
                  1:       pos = area + 1;
                  2:       pos = $urandom_range((1 << POS_W) - 1, area + 1);
                  3:       pos = 1;
                  4:       pos = area;
                  default: pos = $urandom_range(area, 1);
               endcase
               issue_query(pos);
            end
         end
         drain();
      end

      send_idle_pct = 0;
      stall_pct     = 0;
      drain();
      repeat (25) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/skl_pkg.sv
rtl/core/skl_ram.sv
rtl/core/skl_ring_walk.sv
rtl/core/spiral_kth_element_lookup_core.sv
tb/sv/spiral_lookup_checker.sv
tb/sv/spiral_kth_element_lookup_core_tb.sv
